@@ rtl/dmwtc_pkg.sv @@
// ----------------------------------------------------------------------------
// dmwtc_pkg
// Shared sizes, status codes, register indexes and state type for the
// direct-mapped write-through cache.
// ----------------------------------------------------------------------------
package dmwtc_pkg;

    // Storage sizes
    localparam int MEM_DEPTH   = 4096;
    localparam int CACHE_DEPTH = 256;
    localparam int DATA_W      = 32;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    localparam int CACHE_AW    = $clog2(CACHE_DEPTH);
    localparam int CNT_W       = CACHE_AW + 1;
    localparam int LG_W        = 4;

    // Largest log2 sizes that fit the storage
    localparam logic [LG_W-1:0] MEM_LG_MAX   = LG_W'(MEM_AW);
    localparam logic [LG_W-1:0] CACHE_LG_MAX = LG_W'(CACHE_AW);

    // Port field widths
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 64;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_LG   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_LG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LG = 2'd2;

    // Response status codes
    localparam logic [STATUS_W-1:0] STAT_HIT   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_CFG   = 2'd3;

    // Request commands
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_CMP,
        ST_FILL,
        ST_HREAD,
        ST_RESP,
        ST_CLEAR
    } t_state;

endpackage

@@ rtl/dmwtc_ram.sv @@
// ----------------------------------------------------------------------------
// dmwtc_ram
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module dmwtc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/direct_mapped_write_through_cache_top.sv @@
// ----------------------------------------------------------------------------
// direct_mapped_write_through_cache_top
// Direct-mapped, write-through, write-allocate cache over a word-addressed
// backing memory, with data, tag and backing storage in single-port-read RAMs.
// Errors go from lookup straight to the response; a hit passes the tag compare, and a
// hit read also a data read; a miss, for read or write, first fills the whole block.
// One request at a time: the next request is taken only after the response is
// loaded into the output register.
// Reset and every write to a defined register clear all valid bits and start a
// reload pass over the backing memory; no request is taken during it.
// ----------------------------------------------------------------------------
module direct_mapped_write_through_cache_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request: tdata = address[11:0], write_value[43:12], zero[47:44]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    // tuser = cmd[0]
    input  logic        s_axis_tuser,
    // Response: tdata = line_index[7:0], word_offset[15:8], tag_value[27:16],
    // read_value[59:28], zero[63:60]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,
    // tuser = status[1:0]
    output logic [1:0]  m_axis_tuser,
    // Configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    localparam int AW = dmwtc_pkg::MEM_AW;
    localparam int CW = dmwtc_pkg::CACHE_AW;
    localparam int DW = dmwtc_pkg::DATA_W;
    localparam int NW = dmwtc_pkg::CNT_W;
    localparam int LW = dmwtc_pkg::LG_W;
    localparam int CACHE_DEPTH_BITS = dmwtc_pkg::CACHE_DEPTH;

    // Registers
    dmwtc_pkg::t_state r_state, n_state;
    logic [LW-1:0]  r_mem_lg, r_cache_lg, r_block_lg;
    logic           r_cmd;
    logic [AW-1:0]  r_addr;
    logic [DW-1:0]  r_wval;
    logic [CACHE_DEPTH_BITS-1:0] r_valid;
    logic [NW-1:0]  r_cnt, n_cnt;
    logic           r_pend, n_pend;
    logic [CW-1:0]  r_pidx, n_pidx;
    logic [DW-1:0]  r_cap, n_cap;
    logic [AW-1:0]  r_clr_idx, n_clr_idx;
    logic [1:0]     r_res_status, n_res_status;
    logic [CW-1:0]  r_res_line, n_res_line;
    logic [CW-1:0]  r_res_word, n_res_word;
    logic [AW-1:0]  r_res_tag, n_res_tag;
    logic [DW-1:0]  r_res_val, n_res_val;
    logic           r_ovalid;
    logic [1:0]     r_o_status;
    logic [CW-1:0]  r_o_line, r_o_word;
    logic [AW-1:0]  r_o_tag;
    logic [DW-1:0]  r_o_val;

    // Address decode
    logic [LW-1:0]  mlg, clg;
    logic [AW:0]    msize;
    logic           bad_cfg, out_range;
    logic [AW-1:0]  tag, base;
    logic [CW-1:0]  slot, line, word, bmask, slot_base;
    logic [NW-1:0]  bsize;
    logic [DW-1:0]  clr_val;

    // RAM ports and control
    logic           req_acc, cfg_acc, cfg_load, out_load, set_valid, hit;
    logic           c_we, t_we, m_we;
    logic [CW-1:0]  c_waddr;
    logic [DW-1:0]  c_wdata, c_rdata, m_wdata, m_rdata;
    logic [AW-1:0]  t_rdata, m_waddr, m_raddr;

    assign req_acc  = s_axis_tvalid && s_axis_tready;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    // Only a defined register index reloads; any other write is dropped
    assign cfg_load = cfg_acc && (i_cfg_index <= dmwtc_pkg::CFG_BLOCK_LG);
    assign out_load = (r_state == dmwtc_pkg::ST_RESP) && (!r_ovalid || m_axis_tready);

    // Saturate sizes to the storage and split the address
    always_comb begin
        mlg       = (r_mem_lg > dmwtc_pkg::MEM_LG_MAX) ? dmwtc_pkg::MEM_LG_MAX : r_mem_lg;
        clg       = (r_cache_lg > dmwtc_pkg::CACHE_LG_MAX) ? dmwtc_pkg::CACHE_LG_MAX
                                                           : r_cache_lg;
        msize     = (AW+1)'(1) << mlg;
        bad_cfg   = r_block_lg > clg;
        out_range = {1'b0, r_addr} >= msize;
        tag       = r_addr >> clg;
        slot      = r_addr[CW-1:0] & CW'((NW'(1) << clg) - NW'(1));
        bsize     = NW'(1) << r_block_lg;
        bmask     = CW'(bsize - NW'(1));
        line      = slot >> r_block_lg;
        word      = r_addr[CW-1:0] & bmask;
        slot_base = slot & ~bmask;
        base      = r_addr & ~{{(AW-CW){1'b0}}, bmask};
        clr_val   = ({1'b0, r_clr_idx} < msize) ? DW'(msize - {1'b0, r_clr_idx}) : '0;
        hit       = r_valid[line] && (t_rdata == tag);
    end

    // Cache data RAM
    dmwtc_ram #(.WIDTH(DW), .DEPTH(dmwtc_pkg::CACHE_DEPTH)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (slot),
        .o_rdata (c_rdata)
    );

    // Line tag RAM
    dmwtc_ram #(.WIDTH(AW), .DEPTH(dmwtc_pkg::CACHE_DEPTH)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (line),
        .i_wdata (tag),
        .i_raddr (line),
        .o_rdata (t_rdata)
    );

    // Backing memory
    assign m_raddr = base | {{(AW-CW){1'b0}}, r_cnt[CW-1:0]};

    dmwtc_ram #(.WIDTH(DW), .DEPTH(dmwtc_pkg::MEM_DEPTH)) u_back_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    // Next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_pend       = 1'b0;
        n_pidx       = r_pidx;
        n_cap        = r_cap;
        n_clr_idx    = r_clr_idx;
        n_res_status = r_res_status;
        n_res_line   = r_res_line;
        n_res_word   = r_res_word;
        n_res_tag    = r_res_tag;
        n_res_val    = r_res_val;
        set_valid    = 1'b0;
        c_we         = 1'b0;
        c_waddr      = slot;
        c_wdata      = r_wval;
        t_we         = 1'b0;
        m_we         = 1'b0;
        m_waddr      = r_addr;
        m_wdata      = r_wval;

        unique case (r_state)
            dmwtc_pkg::ST_IDLE: begin
                if (req_acc) begin
                    n_state = dmwtc_pkg::ST_LOOK;
                end
            end
            dmwtc_pkg::ST_LOOK: begin
                n_res_line = line;
                n_res_word = word;
                n_res_tag  = tag;
                if (bad_cfg || out_range) begin
                    n_res_status = bad_cfg ? dmwtc_pkg::STAT_CFG : dmwtc_pkg::STAT_RANGE;
                    n_res_line   = '0;
                    n_res_word   = '0;
                    n_res_tag    = '0;
                    n_res_val    = '0;
                    n_state      = dmwtc_pkg::ST_RESP;
                end else begin
                    n_state = dmwtc_pkg::ST_CMP;
                end
            end
            dmwtc_pkg::ST_CMP: begin
                if (hit) begin
                    n_res_status = dmwtc_pkg::STAT_HIT;
                    if (r_cmd == dmwtc_pkg::CMD_WRITE) begin
                        c_we      = 1'b1;
                        m_we      = 1'b1;
                        n_res_val = r_wval;
                        n_state   = dmwtc_pkg::ST_RESP;
                    end else begin
                        n_state = dmwtc_pkg::ST_HREAD;
                    end
                end else begin
                    n_res_status = dmwtc_pkg::STAT_MISS;
                    set_valid    = 1'b1;
                    t_we         = 1'b1;
                    n_cnt        = '0;
                    n_state      = dmwtc_pkg::ST_FILL;
                end
            end
            dmwtc_pkg::ST_FILL: begin
                // Issue block reads, write returning words into the line
                if (r_cnt < bsize) begin
                    n_cnt  = r_cnt + NW'(1);
                    n_pend = 1'b1;
                    n_pidx = r_cnt[CW-1:0];
                end
                if (r_pend) begin
                    c_we    = 1'b1;
                    c_waddr = slot_base | r_pidx;
                    c_wdata = m_rdata;
                    if (r_pidx == word) begin
                        n_cap = m_rdata;
                    end
                end
                if ((r_cnt == bsize) && !r_pend) begin
                    if (r_cmd == dmwtc_pkg::CMD_WRITE) begin
                        c_we      = 1'b1;
                        m_we      = 1'b1;
                        n_res_val = r_wval;
                    end else begin
                        n_res_val = r_cap;
                    end
                    n_state = dmwtc_pkg::ST_RESP;
                end
            end
            dmwtc_pkg::ST_HREAD: begin
                n_res_val = c_rdata;
                n_state   = dmwtc_pkg::ST_RESP;
            end
            dmwtc_pkg::ST_RESP: begin
                if (out_load) begin
                    n_state = dmwtc_pkg::ST_IDLE;
                end
            end
            dmwtc_pkg::ST_CLEAR: begin
                // Reload backing memory with its initial contents
                m_we      = 1'b1;
                m_waddr   = r_clr_idx;
                m_wdata   = clr_val;
                n_clr_idx = r_clr_idx + AW'(1);
                if (r_clr_idx == AW'(dmwtc_pkg::MEM_DEPTH - 1)) begin
                    n_state = dmwtc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dmwtc_pkg::ST_CLEAR;
            end
        endcase

        // Restart the reload pass on any write to a defined register
        if (cfg_load) begin
            n_state   = dmwtc_pkg::ST_CLEAR;
            n_clr_idx = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= dmwtc_pkg::ST_CLEAR;
            r_clr_idx  <= '0;
            r_mem_lg   <= 4'd12;
            r_cache_lg <= 4'd8;
            r_block_lg <= 4'd2;
            r_valid    <= '0;
            r_pend     <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_pend    <= n_pend;
            r_cnt     <= n_cnt;
            if (cfg_load) begin
                r_valid <= '0;
                unique case (i_cfg_index)
                    dmwtc_pkg::CFG_MEM_LG:   r_mem_lg   <= i_cfg_data;
                    dmwtc_pkg::CFG_CACHE_LG: r_cache_lg <= i_cfg_data;
                    dmwtc_pkg::CFG_BLOCK_LG: r_block_lg <= i_cfg_data;
                    default: ;
                endcase
            end else if (set_valid) begin
                r_valid[line] <= 1'b1;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_cmd  <= s_axis_tuser;
            r_addr <= s_axis_tdata[11:0];
            r_wval <= s_axis_tdata[43:12];
        end
        r_pidx       <= n_pidx;
        r_cap        <= n_cap;
        r_res_status <= n_res_status;
        r_res_line   <= n_res_line;
        r_res_word   <= n_res_word;
        r_res_tag    <= n_res_tag;
        r_res_val    <= n_res_val;
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status <= r_res_status;
            r_o_line   <= r_res_line;
            r_o_word   <= r_res_word;
            r_o_tag    <= r_res_tag;
            r_o_val    <= r_res_val;
        end
    end

    assign s_axis_tready = (r_state == dmwtc_pkg::ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {4'b0, r_o_val, r_o_tag, r_o_word, r_o_line};

endmodule

@@ rtl/dmwtc_checker.sv @@
// ----------------------------------------------------------------------------
// dmwtc_checker
// Port-level checks for the direct-mapped write-through cache, bound to the
// top level.
// ----------------------------------------------------------------------------
module dmwtc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [1:0]  i_cfg_index
);

    // Hold a response until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("response dropped while stalled");

    // Error responses carry zero payload
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == dmwtc_pkg::STAT_RANGE ||
                          m_axis_tuser == dmwtc_pkg::STAT_CFG) |-> m_axis_tdata == '0)
        else $error("error response with nonzero payload");

    // Reset starts the reload pass, which blocks requests
    a_rst_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("request accepted right after reset");

    // A write to a defined register restarts the reload pass
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready && (i_cfg_index <= dmwtc_pkg::CFG_BLOCK_LG)
        |=> !s_axis_tready)
        else $error("request accepted right after register write");

    // One request at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request accepted back to back");

endmodule

bind direct_mapped_write_through_cache_top dmwtc_checker u_dmwtc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready),
    .i_cfg_index   (i_cfg_index)
);
